/* design/lmcp_pkg.sv */
package lmcp_pkg;

    // Command codes; the same value is reported as command_kind
    localparam logic [3:0] CMD_CLEAR             = 4'd0;
    localparam logic [3:0] CMD_DOT               = 4'd1;
    localparam logic [3:0] CMD_BLEND_BOX         = 4'd2;
    localparam logic [3:0] CMD_BLEND_FILL_BOX    = 4'd3;
    localparam logic [3:0] CMD_BOX               = 4'd4;
    localparam logic [3:0] CMD_SOLID_BOX         = 4'd5;
    localparam logic [3:0] CMD_BLEND_LINE        = 4'd6;
    localparam logic [3:0] CMD_SEGMENT           = 4'd7;
    localparam logic [3:0] CMD_RING              = 4'd8;
    localparam logic [3:0] CMD_DISC              = 4'd9;
    localparam logic [3:0] CMD_BLEND_FILL_CIRCLE = 4'd10;
    localparam logic [3:0] CMD_BLEND_REPLACE     = 4'd11;
    localparam logic [3:0] CMD_BLEND_MULTIPLY    = 4'd14;
    localparam logic [3:0] GROUP_IDLE            = 4'd15;

    // colour nibble value rejected by the checks
    localparam logic [3:0] NIBBLE_BAD = 4'hF;

    typedef enum logic [3:0] {
        ROLE_NONE,
        ROLE_POS_A,
        ROLE_POS_B,
        ROLE_RADIUS,
        ROLE_A_HI,
        ROLE_A_LO,
        ROLE_AB,
        ROLE_B_LO,
        ROLE_C_HI,
        ROLE_CD,
        ROLE_D_LO
    } role_t;

    typedef struct packed {
        logic [3:0]  group;
        logic [3:0]  step;
        logic [3:0]  p1_x;
        logic [3:0]  p1_y;
        logic [7:0]  p2_x;
        logic [3:0]  p2_y;
        logic [11:0] colour_a;
        logic [11:0] colour_b;
        logic [11:0] colour_c;
        logic [11:0] colour_d;
    } parser_state_t;

    typedef struct packed {
        logic [7:0]  echo_byte;
        logic        accepted;
        logic        command_ready;
        logic [3:0]  command_kind;
        logic [3:0]  first_x;
        logic [3:0]  first_y;
        logic [7:0]  second_x;
        logic [3:0]  second_y;
        logic [11:0] colour_a;
        logic [11:0] colour_b;
        logic [11:0] colour_c;
        logic [11:0] colour_d;
    } parser_result_t;

    function automatic logic [3:0] run_length(input logic [3:0] group);
        logic [3:0] len;
        len = 4'd0;
        unique case (group)
            CMD_DOT:                                  len = 4'd3;
            CMD_BLEND_BOX, CMD_BLEND_FILL_BOX:        len = 4'd8;
            CMD_BLEND_LINE, CMD_BLEND_FILL_CIRCLE:    len = 4'd5;
            CMD_BOX, CMD_SOLID_BOX, CMD_SEGMENT,
            CMD_RING, CMD_DISC:                       len = 4'd4;
            default:                                  len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic role_t run_role(input logic [3:0] group, input logic [3:0] step);
        role_t role;
        role = ROLE_NONE;
        unique case (group)
            CMD_DOT:
            begin
                case (step)
                    4'd0:    role = ROLE_POS_A;
                    4'd1:    role = ROLE_A_HI;
                    4'd2:    role = ROLE_A_LO;
                    default: role = ROLE_NONE;
                endcase
            end
            CMD_BLEND_BOX, CMD_BLEND_FILL_BOX:
            begin
                case (step)
                    4'd0:    role = ROLE_POS_A;
                    4'd1:    role = ROLE_POS_B;
                    4'd2:    role = ROLE_A_HI;
                    4'd3:    role = ROLE_AB;
                    4'd4:    role = ROLE_B_LO;
                    4'd5:    role = ROLE_C_HI;
                    4'd6:    role = ROLE_CD;
                    4'd7:    role = ROLE_D_LO;
                    default: role = ROLE_NONE;
                endcase
            end
            CMD_BOX, CMD_SOLID_BOX, CMD_SEGMENT:
            begin
                case (step)
                    4'd0:    role = ROLE_POS_A;
                    4'd1:    role = ROLE_POS_B;
                    4'd2:    role = ROLE_A_HI;
                    4'd3:    role = ROLE_A_LO;
                    default: role = ROLE_NONE;
                endcase
            end
            CMD_BLEND_LINE:
            begin
                case (step)
                    4'd0:    role = ROLE_POS_A;
                    4'd1:    role = ROLE_POS_B;
                    4'd2:    role = ROLE_A_HI;
                    4'd3:    role = ROLE_AB;
                    4'd4:    role = ROLE_B_LO;
                    default: role = ROLE_NONE;
                endcase
            end
            CMD_RING, CMD_DISC:
            begin
                case (step)
                    4'd0:    role = ROLE_POS_A;
                    4'd1:    role = ROLE_RADIUS;
                    4'd2:    role = ROLE_A_HI;
                    4'd3:    role = ROLE_A_LO;
                    default: role = ROLE_NONE;
                endcase
            end
            CMD_BLEND_FILL_CIRCLE:
            begin
                case (step)
                    4'd0:    role = ROLE_POS_A;
                    4'd1:    role = ROLE_RADIUS;
                    4'd2:    role = ROLE_A_HI;
                    4'd3:    role = ROLE_AB;
                    4'd4:    role = ROLE_B_LO;
                    default: role = ROLE_NONE;
                endcase
            end
            default: role = ROLE_NONE;
        endcase
        return role;
    endfunction

endpackage

/* design/lmcp_step.sv */
module lmcp_step
(
    input  lmcp_pkg::parser_state_t  cur,
    input  logic [7:0]               rx_byte,
    output lmcp_pkg::parser_state_t  nxt,
    output lmcp_pkg::parser_result_t res
);

    lmcp_pkg::role_t role;
    logic            ok;
    logic            emit_now;
    logic [3:0]      emit_kind;
    logic            is_dot;
    logic            is_bbox;
    logic            use_pos1;
    logic            use_pos2;
    logic            use_rad;
    logic            use_cb;
    logic            use_cd;

    always_comb
    begin
        nxt       = cur;
        res       = '0;
        res.echo_byte = rx_byte;
        res.accepted  = 1'b1;
        ok        = 1'b1;
        role      = lmcp_pkg::ROLE_NONE;
        emit_now  = 1'b0;
        emit_kind = cur.group;
        is_dot    = (cur.group == lmcp_pkg::CMD_DOT);
        is_bbox   = (cur.group == lmcp_pkg::CMD_BLEND_BOX);

        if (cur.group == lmcp_pkg::GROUP_IDLE)
        begin
            if (rx_byte == {4'd0, lmcp_pkg::CMD_CLEAR}
                || (rx_byte >= {4'd0, lmcp_pkg::CMD_BLEND_REPLACE}
                    && rx_byte <= {4'd0, lmcp_pkg::CMD_BLEND_MULTIPLY}))
            begin
                emit_now  = 1'b1;
                emit_kind = rx_byte[3:0];
            end
            else if (rx_byte <= {4'd0, lmcp_pkg::CMD_BLEND_FILL_CIRCLE})
            begin
                nxt.group = rx_byte[3:0];
                nxt.step  = 4'd0;
            end
            else
            begin
                res.accepted = 1'b0;
            end
        end
        else
        begin
            role = lmcp_pkg::run_role(cur.group, cur.step);
            // checks run right after each store; a failing store keeps its data
            case (role)
                lmcp_pkg::ROLE_POS_A:
                begin
                    nxt.p1_x = rx_byte[7:4];
                    nxt.p1_y = rx_byte[3:0];
                end
                lmcp_pkg::ROLE_POS_B:
                begin
                    nxt.p2_x = {4'd0, rx_byte[7:4]};
                    nxt.p2_y = rx_byte[3:0];
                end
                lmcp_pkg::ROLE_RADIUS:
                begin
                    nxt.p2_x = rx_byte;
                end
                lmcp_pkg::ROLE_A_HI:
                begin
                    nxt.colour_a = {rx_byte, 4'd0};
                    if ((is_dot || is_bbox) && rx_byte[7:4] == lmcp_pkg::NIBBLE_BAD)
                        ok = 1'b0;
                    if (is_bbox && rx_byte[3:0] == lmcp_pkg::NIBBLE_BAD)
                        ok = 1'b0;
                end
                lmcp_pkg::ROLE_A_LO:
                begin
                    nxt.colour_a = cur.colour_a | {8'd0, rx_byte[7:4]};
                    if (is_dot && (nxt.colour_a[7:4] == lmcp_pkg::NIBBLE_BAD
                                   || nxt.colour_a[3:0] == lmcp_pkg::NIBBLE_BAD))
                        ok = 1'b0;
                end
                lmcp_pkg::ROLE_AB:
                begin
                    nxt.colour_a = cur.colour_a | {8'd0, rx_byte[7:4]};
                    if (is_bbox && nxt.colour_a[3:0] == lmcp_pkg::NIBBLE_BAD)
                        ok = 1'b0;
                    else
                    begin
                        nxt.colour_b = {rx_byte[3:0], 8'd0};
                        if (is_bbox && rx_byte[3:0] == lmcp_pkg::NIBBLE_BAD)
                            ok = 1'b0;
                    end
                end
                lmcp_pkg::ROLE_B_LO:
                begin
                    nxt.colour_b = cur.colour_b | {4'd0, rx_byte};
                    if (is_bbox && (nxt.colour_b[7:4] == lmcp_pkg::NIBBLE_BAD
                                    || nxt.colour_b[3:0] == lmcp_pkg::NIBBLE_BAD))
                        ok = 1'b0;
                end
                lmcp_pkg::ROLE_C_HI:
                begin
                    nxt.colour_c = {rx_byte, 4'd0};
                    if (is_bbox && (rx_byte[7:4] == lmcp_pkg::NIBBLE_BAD
                                    || rx_byte[3:0] == lmcp_pkg::NIBBLE_BAD))
                        ok = 1'b0;
                end
                lmcp_pkg::ROLE_CD:
                begin
                    nxt.colour_c = cur.colour_c | {8'd0, rx_byte[7:4]};
                    if (is_bbox && nxt.colour_c[3:0] == lmcp_pkg::NIBBLE_BAD)
                        ok = 1'b0;
                    else
                    begin
                        nxt.colour_d = {rx_byte[3:0], 8'd0};
                        if (is_bbox && rx_byte[3:0] == lmcp_pkg::NIBBLE_BAD)
                            ok = 1'b0;
                    end
                end
                lmcp_pkg::ROLE_D_LO:
                begin
                    nxt.colour_d = cur.colour_d | {4'd0, rx_byte};
                    if (is_bbox && (nxt.colour_d[7:4] == lmcp_pkg::NIBBLE_BAD
                                    || nxt.colour_d[3:0] == lmcp_pkg::NIBBLE_BAD))
                        ok = 1'b0;
                end
                default:
                begin
                    ok = 1'b0;
                end
            endcase

            if (!ok)
            begin
                nxt.group    = lmcp_pkg::GROUP_IDLE;
                nxt.step     = 4'd0;
                res.accepted = 1'b0;
            end
            else if (cur.step == lmcp_pkg::run_length(cur.group) - 4'd1)
            begin
                emit_now  = 1'b1;
                nxt.group = lmcp_pkg::GROUP_IDLE;
                nxt.step  = 4'd0;
            end
            else
            begin
                nxt.step = cur.step + 4'd1;
            end
        end

        use_pos1 = (emit_kind >= lmcp_pkg::CMD_DOT
                    && emit_kind <= lmcp_pkg::CMD_BLEND_FILL_CIRCLE);
        use_pos2 = (emit_kind >= lmcp_pkg::CMD_BLEND_BOX && emit_kind <= lmcp_pkg::CMD_SEGMENT);
        use_rad  = (emit_kind >= lmcp_pkg::CMD_RING
                    && emit_kind <= lmcp_pkg::CMD_BLEND_FILL_CIRCLE);
        use_cd   = (emit_kind == lmcp_pkg::CMD_BLEND_BOX
                    || emit_kind == lmcp_pkg::CMD_BLEND_FILL_BOX);
        use_cb   = use_cd || emit_kind == lmcp_pkg::CMD_BLEND_LINE
                   || emit_kind == lmcp_pkg::CMD_BLEND_FILL_CIRCLE;

        if (emit_now)
        begin
            res.command_ready = 1'b1;
            res.command_kind  = emit_kind;
            res.first_x       = use_pos1 ? nxt.p1_x : 4'd0;
            res.first_y       = use_pos1 ? nxt.p1_y : 4'd0;
            res.second_x      = (use_pos2 || use_rad) ? nxt.p2_x : 8'd0;
            res.second_y      = use_pos2 ? nxt.p2_y : 4'd0;
            res.colour_a      = use_pos1 ? nxt.colour_a : 12'd0;
            res.colour_b      = use_cb ? nxt.colour_b : 12'd0;
            res.colour_c      = use_cd ? nxt.colour_c : 12'd0;
            res.colour_d      = use_cd ? nxt.colour_d : 12'd0;
        end
    end

endmodule

/* design/led_matrix_command_parser_core.sv */
// Byte-stream command parser for a 16x16 LED matrix link. Every accepted rx_byte yields exactly
// one result in the next cycle: the byte echoed, an accepted flag and, on the last byte of a
// command, a decoded draw command with command_ready set. One byte is taken per cycle; the only
// limit is the single result register, which accepts a new byte whenever it is empty or being
// drained in the same cycle. An unknown command or a failed colour check clears accepted and
// returns the parser to idle; stored points and colours are kept.
module led_matrix_command_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  echo_byte,
    output logic        accepted,
    output logic        command_ready,
    output logic [3:0]  command_kind,
    output logic [3:0]  first_x,
    output logic [3:0]  first_y,
    output logic [7:0]  second_x,
    output logic [3:0]  second_y,
    output logic [11:0] colour_a,
    output logic [11:0] colour_b,
    output logic [11:0] colour_c,
    output logic [11:0] colour_d
);

    lmcp_pkg::parser_state_t  state_reg;
    lmcp_pkg::parser_state_t  state_next;
    lmcp_pkg::parser_result_t result_reg;
    lmcp_pkg::parser_result_t result_next;
    logic                     out_valid_reg;
    logic                     in_xfer;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    lmcp_step u_step
    (
        .cur     (state_reg),
        .rx_byte (rx_byte),
        .nxt     (state_next),
        .res     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= '0;
            state_reg.group <= lmcp_pkg::GROUP_IDLE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_xfer)
                state_reg <= state_next;
            if (in_xfer)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            result_reg <= result_next;
    end

    assign out_valid     = out_valid_reg;
    assign echo_byte     = result_reg.echo_byte;
    assign accepted      = result_reg.accepted;
    assign command_ready = result_reg.command_ready;
    assign command_kind  = result_reg.command_kind;
    assign first_x       = result_reg.first_x;
    assign first_y       = result_reg.first_y;
    assign second_x      = result_reg.second_x;
    assign second_y      = result_reg.second_y;
    assign colour_a      = result_reg.colour_a;
    assign colour_b      = result_reg.colour_b;
    assign colour_c      = result_reg.colour_c;
    assign colour_d      = result_reg.colour_d;

    // a rejected byte always leaves the parser idle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && !result_next.accepted |=> state_reg.group == lmcp_pkg::GROUP_IDLE)
        else $error("parser not idle after rejected byte");

    // an issued command ends the run
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && result_next.command_ready |=> state_reg.group == lmcp_pkg::GROUP_IDLE
                                                 && state_reg.step == 4'd0)
        else $error("parser not idle after issued command");

    // only groups with a parameter run are ever entered
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.group == lmcp_pkg::GROUP_IDLE
        || (state_reg.group >= lmcp_pkg::CMD_DOT
            && state_reg.group <= lmcp_pkg::CMD_BLEND_FILL_CIRCLE))
        else $error("parser in group without parameter run");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.command_ready |-> result_reg.accepted)
        else $error("command issued on rejected byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.command_ready |-> result_reg.command_kind == 4'd0
            && result_reg.colour_a == 12'd0 && result_reg.second_x == 8'd0)
        else $error("command fields set without command");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> out_valid_reg)
        else $error("transfer in without result");

endmodule

/* tb/sv/command_stream_checker.sv */
`timescale 1ns / 100ps

module command_stream_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  echo_byte,
    input  logic        accepted,
    input  logic        command_ready,
    input  logic [3:0]  command_kind,
    input  logic [3:0]  first_x,
    input  logic [3:0]  first_y,
    input  logic [7:0]  second_x,
    input  logic [3:0]  second_y,
    input  logic [11:0] colour_a,
    input  logic [11:0] colour_b,
    input  logic [11:0] colour_c,
    input  logic [11:0] colour_d,
    output int          error_count,
    output int          outstanding,
    output int          commands_issued,
    output int          bytes_rejected,
    output logic [14:0] kinds_issued
);

    // shadow of the parser state
    logic [3:0]  group_q;
    logic [3:0]  step_q;
    logic [3:0]  pt_one_x;
    logic [3:0]  pt_one_y;
    logic [7:0]  pt_two_x;
    logic [3:0]  pt_two_y;
    logic [11:0] stored_a;
    logic [11:0] stored_b;
    logic [11:0] stored_c;
    logic [11:0] stored_d;

    lmcp_pkg::parser_result_t predicted_results[$];
    lmcp_pkg::parser_result_t want;
    int             failures;
    int             reported;
    int             result_idx;
    int             issued;
    int             rejected;
    logic [14:0]    kind_mask;

    // fill in the decoded command; fields the command does not use stay zero
    function automatic lmcp_pkg::parser_result_t with_command(
        input lmcp_pkg::parser_result_t r, input logic [3:0] kind);
        bit pt1;
        bit pt2;
        bit round;
        bit two_col;
        bit four_col;
        pt1 = kind >= lmcp_pkg::CMD_DOT && kind <= lmcp_pkg::CMD_BLEND_FILL_CIRCLE;
        pt2 = kind >= lmcp_pkg::CMD_BLEND_BOX && kind <= lmcp_pkg::CMD_SEGMENT;
        round = kind >= lmcp_pkg::CMD_RING && kind <= lmcp_pkg::CMD_BLEND_FILL_CIRCLE;
        four_col = kind == lmcp_pkg::CMD_BLEND_BOX || kind == lmcp_pkg::CMD_BLEND_FILL_BOX;
        two_col = four_col || kind == lmcp_pkg::CMD_BLEND_LINE
                  || kind == lmcp_pkg::CMD_BLEND_FILL_CIRCLE;
        r.command_ready = 1'b1;
        r.command_kind = kind;
        if (pt1)
        begin
            r.first_x = pt_one_x;
            r.first_y = pt_one_y;
            r.colour_a = stored_a;
        end
        if (pt2 || round)
            r.second_x = pt_two_x;
        if (pt2)
            r.second_y = pt_two_y;
        if (two_col)
            r.colour_b = stored_b;
        if (four_col)
        begin
            r.colour_c = stored_c;
            r.colour_d = stored_d;
        end
        return r;
    endfunction

    function automatic lmcp_pkg::parser_result_t decode_byte(input logic [7:0] b);
        lmcp_pkg::parser_result_t r;
        lmcp_pkg::role_t          role;
        bit             dot;
        bit             bbox;
        bit             round;
        bit             two_col;
        bit             four_col;
        bit             ok;
        logic [3:0]     last;
        r = '0;
        r.echo_byte = b;
        r.accepted = 1'b1;
        if (group_q == lmcp_pkg::GROUP_IDLE)
        begin
            if (b == {4'd0, lmcp_pkg::CMD_CLEAR}
                || (b >= {4'd0, lmcp_pkg::CMD_BLEND_REPLACE}
                    && b <= {4'd0, lmcp_pkg::CMD_BLEND_MULTIPLY}))
                r = with_command(r, b[3:0]);
            else if (b <= {4'd0, lmcp_pkg::CMD_BLEND_FILL_CIRCLE})
            begin
                group_q = b[3:0];
                step_q = '0;
            end
            else
                r.accepted = 1'b0;
            return r;
        end

        dot = group_q == lmcp_pkg::CMD_DOT;
        bbox = group_q == lmcp_pkg::CMD_BLEND_BOX;
        round = group_q >= lmcp_pkg::CMD_RING && group_q <= lmcp_pkg::CMD_BLEND_FILL_CIRCLE;
        four_col = bbox || group_q == lmcp_pkg::CMD_BLEND_FILL_BOX;
        two_col = four_col || group_q == lmcp_pkg::CMD_BLEND_LINE
                  || group_q == lmcp_pkg::CMD_BLEND_FILL_CIRCLE;
        last = dot ? 4'd2 : four_col ? 4'd7 : two_col ? 4'd4 : 4'd3;

        // what the byte at this position of the run carries
        role = lmcp_pkg::ROLE_NONE;
        if (group_q >= lmcp_pkg::CMD_DOT && group_q <= lmcp_pkg::CMD_BLEND_FILL_CIRCLE
            && step_q <= last)
        begin
            if (dot)
            begin
                case (step_q)
                    4'd0:    role = lmcp_pkg::ROLE_POS_A;
                    4'd1:    role = lmcp_pkg::ROLE_A_HI;
                    default: role = lmcp_pkg::ROLE_A_LO;
                endcase
            end
            else
            begin
                case (step_q)
                    4'd0:    role = lmcp_pkg::ROLE_POS_A;
                    4'd1:    role = round ? lmcp_pkg::ROLE_RADIUS : lmcp_pkg::ROLE_POS_B;
                    4'd2:    role = lmcp_pkg::ROLE_A_HI;
                    4'd3:    role = two_col ? lmcp_pkg::ROLE_AB : lmcp_pkg::ROLE_A_LO;
                    4'd4:    role = lmcp_pkg::ROLE_B_LO;
                    4'd5:    role = lmcp_pkg::ROLE_C_HI;
                    4'd6:    role = lmcp_pkg::ROLE_CD;
                    default: role = lmcp_pkg::ROLE_D_LO;
                endcase
            end
        end

        // each nibble check fires right after its store; later stores are skipped
        ok = 1'b1;
        case (role)
            lmcp_pkg::ROLE_POS_A:
            begin
                pt_one_x = b[7:4];
                pt_one_y = b[3:0];
            end
            lmcp_pkg::ROLE_POS_B:
            begin
                pt_two_x = {4'd0, b[7:4]};
                pt_two_y = b[3:0];
            end
            lmcp_pkg::ROLE_RADIUS:
                pt_two_x = b;
            lmcp_pkg::ROLE_A_HI:
            begin
                stored_a = {b, 4'd0};
                ok = !((dot || bbox) && stored_a[11:8] == lmcp_pkg::NIBBLE_BAD)
                     && !(bbox && stored_a[7:4] == lmcp_pkg::NIBBLE_BAD);
            end
            lmcp_pkg::ROLE_A_LO:
            begin
                stored_a = stored_a | {8'd0, b[7:4]};
                ok = !(dot && (stored_a[7:4] == lmcp_pkg::NIBBLE_BAD
                               || stored_a[3:0] == lmcp_pkg::NIBBLE_BAD));
            end
            lmcp_pkg::ROLE_AB:
            begin
                stored_a = stored_a | {8'd0, b[7:4]};
                ok = !(bbox && stored_a[3:0] == lmcp_pkg::NIBBLE_BAD);
                if (ok)
                begin
                    stored_b = {b[3:0], 8'd0};
                    ok = !(bbox && stored_b[11:8] == lmcp_pkg::NIBBLE_BAD);
                end
            end
            lmcp_pkg::ROLE_B_LO:
            begin
                stored_b = stored_b | {4'd0, b};
                ok = !(bbox && (stored_b[7:4] == lmcp_pkg::NIBBLE_BAD
                                || stored_b[3:0] == lmcp_pkg::NIBBLE_BAD));
            end
            lmcp_pkg::ROLE_C_HI:
            begin
                stored_c = {b, 4'd0};
                ok = !(bbox && (stored_c[11:8] == lmcp_pkg::NIBBLE_BAD
                                || stored_c[7:4] == lmcp_pkg::NIBBLE_BAD));
            end
            lmcp_pkg::ROLE_CD:
            begin
                stored_c = stored_c | {8'd0, b[7:4]};
                ok = !(bbox && stored_c[3:0] == lmcp_pkg::NIBBLE_BAD);
                if (ok)
                begin
                    stored_d = {b[3:0], 8'd0};
                    ok = !(bbox && stored_d[11:8] == lmcp_pkg::NIBBLE_BAD);
                end
            end
            lmcp_pkg::ROLE_D_LO:
            begin
                stored_d = stored_d | {4'd0, b};
                ok = !(bbox && (stored_d[7:4] == lmcp_pkg::NIBBLE_BAD
                                || stored_d[3:0] == lmcp_pkg::NIBBLE_BAD));
            end
            default:
                ok = 1'b0;
        endcase

        if (!ok)
        begin
            group_q = lmcp_pkg::GROUP_IDLE;
            step_q = '0;
            r.accepted = 1'b0;
        end
        else if (step_q == last)
        begin
            r = with_command(r, group_q);
            group_q = lmcp_pkg::GROUP_IDLE;
            step_q = '0;
        end
        else
            step_q = step_q + 4'd1;
        return r;
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (reported < 10)
        begin
            $display("[%0t] %s", $realtime, msg);
            reported++;
        end
    endtask

    task automatic check_field(input string field, input logic [11:0] exp_val,
                               input logic [11:0] got);
        if (got !== exp_val)
            note_failure($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
                                   result_idx, field, exp_val, got));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_q = lmcp_pkg::GROUP_IDLE;
            step_q = '0;
            pt_one_x = '0;
            pt_one_y = '0;
            pt_two_x = '0;
            pt_two_y = '0;
            stored_a = '0;
            stored_b = '0;
            stored_c = '0;
            stored_d = '0;
            predicted_results.delete();
            failures = 0;
            reported = 0;
            result_idx = 0;
            issued = 0;
            rejected = 0;
            kind_mask = '0;
        end
        else
        begin
            // result side first: the byte taken at this edge is answered by a later result
            if (out_valid && out_ready)
            begin
                if (predicted_results.size() == 0)
                    note_failure($sformatf("result %0d arrived with none expected (echo 0x%0h)",
                                           result_idx, echo_byte));
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("echo_byte", {4'd0, want.echo_byte}, {4'd0, echo_byte});
                    check_field("accepted", {11'd0, want.accepted}, {11'd0, accepted});
                    check_field("command_ready", {11'd0, want.command_ready},
                                {11'd0, command_ready});
                    check_field("command_kind", {8'd0, want.command_kind},
                                {8'd0, command_kind});
                    check_field("first_x", {8'd0, want.first_x}, {8'd0, first_x});
                    check_field("first_y", {8'd0, want.first_y}, {8'd0, first_y});
                    check_field("second_x", {4'd0, want.second_x}, {4'd0, second_x});
                    check_field("second_y", {8'd0, want.second_y}, {8'd0, second_y});
                    check_field("colour_a", want.colour_a, colour_a);
                    check_field("colour_b", want.colour_b, colour_b);
                    check_field("colour_c", want.colour_c, colour_c);
                    check_field("colour_d", want.colour_d, colour_d);
                    if (want.command_ready)
                    begin
                        issued++;
                        kind_mask[want.command_kind] = 1'b1;
                    end
                    if (!want.accepted)
                        rejected++;
                end
                result_idx++;
            end
            if (in_valid && in_ready)
                predicted_results.push_back(decode_byte(rx_byte));
        end
        error_count <= failures;
        outstanding <= predicted_results.size();
        commands_issued <= issued;
        bytes_rejected <= rejected;
        kinds_issued <= kind_mask;
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_BYTES = 470;
    localparam int HOLD_CYCLES  = 150;
    localparam int STALL_LIMIT  = 2000;

    // mode codes between replace and multiply
    localparam logic [3:0] MODE_ADD      = lmcp_pkg::CMD_BLEND_REPLACE + 4'd1;
    localparam logic [3:0] MODE_SUBTRACT = lmcp_pkg::CMD_BLEND_REPLACE + 4'd2;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  echo_byte;
    logic        accepted;
    logic        command_ready;
    logic [3:0]  command_kind;
    logic [3:0]  first_x;
    logic [3:0]  first_y;
    logic [7:0]  second_x;
    logic [3:0]  second_y;
    logic [11:0] colour_a;
    logic [11:0] colour_b;
    logic [11:0] colour_c;
    logic [11:0] colour_d;

    int          error_count;
    int          outstanding;
    int          commands_issued;
    int          bytes_rejected;
    logic [14:0] kinds_issued;

    int bytes_sent = 0;
    int burst_left = 0;
    int gap_max = 6;
    int in_stalls = 0;
    bit hold_request = 1'b0;

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    led_matrix_command_parser_core uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .echo_byte     (echo_byte),
        .accepted      (accepted),
        .command_ready (command_ready),
        .command_kind  (command_kind),
        .first_x       (first_x),
        .first_y       (first_y),
        .second_x      (second_x),
        .second_y      (second_y),
        .colour_a      (colour_a),
        .colour_b      (colour_b),
        .colour_c      (colour_c),
        .colour_d      (colour_d)
    );

    command_stream_checker result_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .echo_byte       (echo_byte),
        .accepted        (accepted),
        .command_ready   (command_ready),
        .command_kind    (command_kind),
        .first_x         (first_x),
        .first_y         (first_y),
        .second_x        (second_x),
        .second_y        (second_y),
        .colour_a        (colour_a),
        .colour_b        (colour_b),
        .colour_c        (colour_c),
        .colour_d        (colour_d),
        .error_count     (error_count),
        .outstanding     (outstanding),
        .commands_issued (commands_issued),
        .bytes_rejected  (bytes_rejected),
        .kinds_issued    (kinds_issued)
    );

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_ready)
            in_stalls++;
    end

    // receiver: random ready duty cycle per mode, plus one long hold-off
    initial
    begin : receiver
        int mode_left;
        int ready_pct;
        bit held;
        mode_left = 0;
        ready_pct = 100;
        held = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request && !held)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode_left = $urandom_range(20, 80);
                    case ($urandom_range(0, 3))
                        0:       ready_pct = 100;
                        1:       ready_pct = 80;
                        2:       ready_pct = 50;
                        default: ready_pct = 15;
                    endcase
                end
                mode_left--;
                out_ready <= ($urandom_range(1, 100) <= ready_pct);
                @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("timeout: no transfer in %0d cycles", STALL_LIMIT);
        $display("led_matrix_command_parser_core regression: fail");
        $finish;
    end

    // one byte per call; a new burst may start with a gap of random length
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                rx_byte <= 8'($urandom_range(0, 255));
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        burst_left--;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_code(input logic [3:0] code);
        send_byte({4'd0, code});
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    function automatic logic [3:0] pick_nibble();
        if ($urandom_range(0, 39) == 0)
            return lmcp_pkg::NIBBLE_BAD;
        return 4'($urandom_range(0, 14));
    endfunction

    // command code then up to keep parameter bytes of its run
    task automatic send_command(input logic [3:0] kind, input int keep);
        int         n;
        int         i;
        logic [7:0] b;
        case (kind)
            lmcp_pkg::CMD_DOT:                                  n = 3;
            lmcp_pkg::CMD_BLEND_BOX, lmcp_pkg::CMD_BLEND_FILL_BOX:
                                                                n = 8;
            lmcp_pkg::CMD_BLEND_LINE, lmcp_pkg::CMD_BLEND_FILL_CIRCLE:
                                                                n = 5;
            lmcp_pkg::CMD_BOX, lmcp_pkg::CMD_SOLID_BOX, lmcp_pkg::CMD_SEGMENT,
            lmcp_pkg::CMD_RING, lmcp_pkg::CMD_DISC:             n = 4;
            default:                                            n = 0;
        endcase
        if (keep < n)
            n = keep;
        send_code(kind);
        for (i = 0; i < n; i++)
        begin
            // colour bytes of the checked commands: mostly legal nibbles
            if ((kind == lmcp_pkg::CMD_DOT && i >= 1)
                || (kind == lmcp_pkg::CMD_BLEND_BOX && i >= 2))
                b = {pick_nibble(), pick_nibble()};
            else if ($urandom_range(0, 4) == 0)
                b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                b = 8'($urandom_range(0, 255));
            send_byte(b);
        end
    endtask

    initial
    begin : stimulus
        int  pick;
        int  random_start;
        bit  pressed;
        bit  paused;
        pressed = 1'b0;
        paused = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // immediate commands and unknown codes
        send_code(lmcp_pkg::CMD_CLEAR);
        send_code(lmcp_pkg::CMD_BLEND_REPLACE);
        send_code(MODE_ADD);
        send_code(MODE_SUBTRACT);
        send_code(lmcp_pkg::CMD_BLEND_MULTIPLY);
        send_code(lmcp_pkg::GROUP_IDLE);
        send_byte(8'hFF);
        // dot: legal extremes, bad high nibble, bad middle nibble on the second byte
        send_code(lmcp_pkg::CMD_DOT); send_byte(8'hFF); send_byte(8'hEE); send_byte(8'hEF);
        send_code(lmcp_pkg::CMD_DOT); send_byte(8'h00); send_byte(8'hF0);
        send_code(lmcp_pkg::CMD_DOT); send_byte(8'h12); send_byte(8'h3F);
        // blend box: first code byte ends the dot; second run fails on the last nibble
        send_code(lmcp_pkg::CMD_BLEND_BOX); send_byte(8'h00); send_byte(8'hFF);
        repeat (6) send_byte(8'hEE);
        send_code(lmcp_pkg::CMD_BLEND_BOX); send_byte(8'h5A); send_byte(8'hA5);
        send_byte(8'h12);
        send_byte(8'h34); send_byte(8'h56); send_byte(8'h78); send_byte(8'h9A);
        send_byte(8'hBF);
        // unchecked commands take nibble 15 freely
        send_code(lmcp_pkg::CMD_BLEND_FILL_BOX); send_byte(8'hFF); send_byte(8'h00);
        repeat (6) send_byte(8'hFF);
        send_code(lmcp_pkg::CMD_BOX); send_byte(8'h00); send_byte(8'hFF); send_byte(8'hFF);
        send_byte(8'hF0);
        send_code(lmcp_pkg::CMD_SOLID_BOX); send_byte(8'hFF); send_byte(8'h00);
        send_byte(8'h00); send_byte(8'h00);
        send_code(lmcp_pkg::CMD_BLEND_LINE); send_byte(8'h0F); send_byte(8'hF0);
        send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
        send_code(lmcp_pkg::CMD_SEGMENT); send_byte(8'hF0); send_byte(8'h0F);
        send_byte(8'h80); send_byte(8'h10);
        send_code(lmcp_pkg::CMD_RING); send_byte(8'h88); send_byte(8'hFF); send_byte(8'h00);
        send_byte(8'hF0);
        send_code(lmcp_pkg::CMD_DISC); send_byte(8'h00); send_byte(8'h00); send_byte(8'hFF);
        send_byte(8'hFF);
        send_code(lmcp_pkg::CMD_BLEND_FILL_CIRCLE); send_byte(8'h77); send_byte(8'h01);
        send_byte(8'hAB); send_byte(8'hCD); send_byte(8'hEF);
        drain_results();

        random_start = bytes_sent;
        while (bytes_sent < random_start + RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       gap_max = 0;
                    1:       gap_max = 3;
                    default: gap_max = 12;
                endcase
            end
            if (!pressed && bytes_sent > random_start + 150)
            begin
                // long receiver hold-off while the sender keeps pushing
                hold_request = 1'b1;
                gap_max = 0;
                burst_left = 0;
                repeat (5)
                    send_command(4'($urandom_range(0, lmcp_pkg::CMD_BLEND_MULTIPLY)), 8);
                pressed = 1'b1;
            end
            else if (!paused && bytes_sent > random_start + 350)
            begin
                drain_results();
                paused = 1'b1;
            end
            else if (pick < 75)
                send_command(4'($urandom_range(0, lmcp_pkg::CMD_BLEND_MULTIPLY)), 8);
            else if (pick < 88)
                send_command(4'($urandom_range(lmcp_pkg::CMD_DOT,
                                               lmcp_pkg::CMD_BLEND_FILL_CIRCLE)),
                             $urandom_range(0, 4));
            else
                send_byte(8'($urandom_range(0, 255)));
        end
        drain_results();
        repeat (4) @(posedge clk);

        $display("%0d bytes sent, %0d commands issued (kind mask 0x%04h), %0d bytes rejected",
                 bytes_sent, commands_issued, kinds_issued, bytes_rejected);
        $display("input stalled %0d cycles, incl. a %0d-cycle result hold-off",
                 in_stalls, HOLD_CYCLES);
        if (error_count == 0 && outstanding == 0)
            $display("led_matrix_command_parser_core regression: pass");
        else
            $display("led_matrix_command_parser_core regression: fail");
        $finish;
    end

endmodule

/* sim.f */
design/lmcp_pkg.sv
design/lmcp_step.sv
design/led_matrix_command_parser_core.sv
tb/sv/command_stream_checker.sv
tb/sv/testbench.sv
